// ===== sv/color_match_column_centroid_assert.svh =====
// ----------------------------------------------------------------------------
// color_match_column_centroid_assert.svh
// Assertion macros shared by the centroid block. They use clk and rst of the
// module that expands them.
// ----------------------------------------------------------------------------
`ifndef COLOR_MATCH_COLUMN_CENTROID_ASSERT_SVH
`define COLOR_MATCH_COLUMN_CENTROID_ASSERT_SVH

// Same-cycle implication
`define CMCC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cmcc assertion failed");

// Next-cycle implication
`define CMCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cmcc assertion failed");

`endif

// ===== sv/cmcc_pkg.sv =====
// ----------------------------------------------------------------------------
// cmcc_pkg
// Types and constants of the color match column centroid block.
// ----------------------------------------------------------------------------
`default_nettype none

package cmcc_pkg;

  localparam int PIX_W  = 8;
  localparam int DIST_W = 10;
  localparam int THR_W  = 10;
  localparam int FW_W   = 11;
  localparam int CNT_W  = 21;
  localparam int SUM_W  = 31;
  localparam int DIR_W  = 16;
  localparam int DEN_W  = 32;   // count * (width-1) fits 32 bits
  localparam int NUM_W  = 48;   // (sum << 16) + den/2

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

  // register indexes
  localparam logic [2:0] REG_REF_RED   = 3'd0;
  localparam logic [2:0] REG_REF_GREEN = 3'd1;
  localparam logic [2:0] REG_REF_BLUE  = 3'd2;
  localparam logic [2:0] REG_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_WIDTH     = 3'd4;

  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic [PIX_W-1:0] ref_red;
    logic [PIX_W-1:0] ref_green;
    logic [PIX_W-1:0] ref_blue;
    logic [THR_W-1:0] match_threshold;
    logic [FW_W-1:0]  frame_width;
  } cfg_t;

  // one finished frame waiting for the divider
  typedef struct packed {
    logic             ok;     // count nonzero and width above one
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic [FW_W-1:0]  wm1;    // effective width minus one
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== sv/cmcc_front.sv =====
// ----------------------------------------------------------------------------
// cmcc_front
// Pixel front end: color distance, column counter and per-frame accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module cmcc_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire                            clk,
  input  wire                            rst,
  input  cmcc_pkg::cfg_t                 cfg,
  input  wire                            s_tvalid,
  output logic                           s_tready,
  input  wire [cmcc_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire                            s_tlast,
  input  cmcc_pkg::q_stat_t              q_stat,
  output logic                           push,
  output cmcc_pkg::job_t                 job
);
  import cmcc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CW-1:0]    col;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] sum;

  logic [FW_W-1:0]   weff;
  logic [CW-1:0]     col0;
  logic [31:0]       col1;
  logic [CW-1:0]     col_next;
  logic [PIX_W-1:0]  d_r, d_g, d_b;
  logic [DIST_W-1:0] color_dist;
  logic              match;
  logic [31:0]       sum_ext;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]  count_next;
  logic              accept;

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  // effective width: zero acts as one, clamp at MAX_WIDTH
  always_comb begin
    if (cfg.frame_width == '0) begin
      weff = FW_W'(1);
    end else if (int'(cfg.frame_width) > MAX_WIDTH) begin
      weff = FW_W'(MAX_WIDTH);
    end else begin
      weff = cfg.frame_width;
    end
  end

  // column counter, wraps before and after use
  always_comb begin
    col0     = (32'(col) >= 32'(weff)) ? '0 : col;
    col1     = 32'(col0) + 32'd1;
    col_next = (col1 >= 32'(weff)) ? '0 : CW'(col1);
  end

  // sum of absolute channel differences
  always_comb begin
    d_r   = (s_tdata[7:0]   > cfg.ref_red)   ? s_tdata[7:0]   - cfg.ref_red
                                              : cfg.ref_red   - s_tdata[7:0];
    d_g   = (s_tdata[15:8]  > cfg.ref_green) ? s_tdata[15:8]  - cfg.ref_green
                                              : cfg.ref_green - s_tdata[15:8];
    d_b   = (s_tdata[23:16] > cfg.ref_blue)  ? s_tdata[23:16] - cfg.ref_blue
                                              : cfg.ref_blue  - s_tdata[23:16];
    color_dist = DIST_W'(d_r) + DIST_W'(d_g) + DIST_W'(d_b);
    match      = color_dist < cfg.match_threshold;
  end

  // saturating accumulators
  always_comb begin
    sum_ext    = 32'(sum) + 32'(col0);
    sum_next   = sum;
    count_next = count;
    if (match) begin
      sum_next = (sum_ext > 32'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];
      if (count != COUNT_MAX) begin
        count_next = count + CNT_W'(1);
      end
    end
  end

  // frame summary for the divider
  always_comb begin
    push      = accept && s_tlast;
    job.ok    = (count_next != '0) && (weff > FW_W'(1));
    job.sum   = sum_next;
    job.count = count_next;
    job.wm1   = weff - FW_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      count <= '0;
      sum   <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        col   <= '0;
        count <= '0;
        sum   <= '0;
      end else begin
        col   <= col_next;
        count <= count_next;
        sum   <= sum_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/cmcc_queue.sv =====
// ----------------------------------------------------------------------------
// cmcc_queue
// Short queue of frame summaries between the front end and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module cmcc_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  cmcc_pkg::job_t     push_job,
  input  wire                pop,
  output cmcc_pkg::job_t     head,
  output cmcc_pkg::q_stat_t  stat
);
  import cmcc_pkg::*;

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  job_t          entries [Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;

  assign stat.full  = (fill == (PW+1)'(Q_DEPTH));
  assign stat.empty = (fill == '0);
  assign head       = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == Q_DEPTH - 1) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == Q_DEPTH - 1) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/cmcc_back.sv =====
// ----------------------------------------------------------------------------
// cmcc_back
// Direction unit: multiply, bit-serial divide, saturate, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cmcc_back (
  input  wire                             clk,
  input  wire                             rst,
  input  cmcc_pkg::job_t                  head,
  input  cmcc_pkg::q_stat_t               q_stat,
  output logic                            pop,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  output logic [cmcc_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tuser
);
  import cmcc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_NUM  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam int STEP_W = $clog2(NUM_W);

  logic [2:0]        state;
  job_t              job;
  logic [DEN_W-1:0]  den;
  logic [NUM_W-1:0]  num;     // dividend, quotient shifts in from the bottom
  logic [DEN_W-1:0]  rem;
  logic [STEP_W-1:0] step;

  logic [DEN_W:0]    rem_sh;
  logic              ge;
  logic [DEN_W:0]    rem_sub;
  logic [DIR_W-1:0]  q16;
  logic [DIR_W-1:0]  dir;
  logic              out_free;

  assign pop      = (state == ST_IDLE) && !q_stat.empty;
  assign out_free = !m_tvalid || m_tready;

  // one restoring division step
  always_comb begin
    rem_sh  = {rem, num[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den};
    rem_sub = rem_sh - {1'b0, den};
  end

  // saturate quotient to 16 bits, then offset to signed
  always_comb begin
    q16 = (|num[NUM_W-1:DIR_W]) ? {DIR_W{1'b1}} : num[DIR_W-1:0];
    dir = job.ok ? {~q16[DIR_W-1], q16[DIR_W-2:0]} : '0;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            state <= head.ok ? ST_MUL : ST_DONE;
          end
        end
        ST_MUL: begin
          state <= ST_NUM;
        end
        ST_NUM: begin
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          step <= step + STEP_W'(1);
          if (32'(step) == NUM_W - 1) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        job <= head;
      end
      ST_MUL: begin
        den <= DEN_W'(job.count) * DEN_W'(job.wm1);
      end
      ST_NUM: begin
        num <= {1'b0, job.sum, {DIR_W{1'b0}}} + NUM_W'(den >> 1);
        rem <= '0;
      end
      ST_DIV: begin
        if (ge) begin
          rem <= rem_sub[DEN_W-1:0];
          num <= {num[NUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DEN_W-1:0];
          num <= {num[NUM_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {{(OUT_DATA_W - CNT_W - DIR_W){1'b0}}, job.count, dir};
      m_tuser <= job.ok;
    end
  end

endmodule

`default_nettype wire

// ===== sv/color_match_column_centroid.sv =====
// ----------------------------------------------------------------------------
// color_match_column_centroid
// Counts pixels near a reference color and reports their column centroid.
// Input stream: one RGB pixel per word, tlast on the last pixel of a frame;
// one pixel per cycle is taken while the frame queue has room.
// Output stream: one word per frame, direction in Q1.15 plus match count,
// tuser flags a valid direction (no match or width of one gives 0).
// The result is computed after the last pixel by the 48-step bit-serial
// divider; short frames back up into the two-entry frame queue and then
// hold s_tready low.
// A stalled receiver holds the output word; the divider then waits and the
// front end keeps taking pixels until the queue fills.
// Reset (rst, synchronous) loads the register defaults and clears the
// column counter, the accumulators, the queue and the output.
// Registers on APB at byte address 4*i; pready is always high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "color_match_column_centroid_assert.svh"

module color_match_column_centroid #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire         clk,
  input  wire         rst,
  // APB configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixels: pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16]
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,
  input  wire         s_tlast,   // end_of_frame
  // results: direction[15:0], match_count[36:16], zero pad [39:37]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,
  output logic        m_tuser    // direction_valid
);
  import cmcc_pkg::*;

  cfg_t    cfg;
  logic    cfg_wr;
  logic    q_push;
  logic    q_pop;
  job_t    q_in;
  job_t    q_head;
  q_stat_t q_stat;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_red         <= 8'd0;
      cfg.ref_green       <= 8'd255;
      cfg.ref_blue        <= 8'd0;
      cfg.match_threshold <= 10'd10;
      cfg.frame_width     <= 11'd320;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_REF_RED:   cfg.ref_red         <= pwdata[PIX_W-1:0];
        REG_REF_GREEN: cfg.ref_green       <= pwdata[PIX_W-1:0];
        REG_REF_BLUE:  cfg.ref_blue        <= pwdata[PIX_W-1:0];
        REG_THRESHOLD: cfg.match_threshold <= pwdata[THR_W-1:0];
        REG_WIDTH:     cfg.frame_width     <= pwdata[FW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:2])
      REG_REF_RED:   prdata = 32'(cfg.ref_red);
      REG_REF_GREEN: prdata = 32'(cfg.ref_green);
      REG_REF_BLUE:  prdata = 32'(cfg.ref_blue);
      REG_THRESHOLD: prdata = 32'(cfg.match_threshold);
      REG_WIDTH:     prdata = 32'(cfg.frame_width);
      default:       prdata = 32'd0;
    endcase
  end

  cmcc_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_stat   (q_stat),
    .push     (q_push),
    .job      (q_in)
  );

  cmcc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  cmcc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .q_stat   (q_stat),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // checks
  `CMCC_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full)
  `CMCC_ASSERT_IMP(a_invalid_dir_zero, m_tvalid && !m_tuser, m_tdata[15:0] == 16'h0000)
  `CMCC_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_stat.empty)

endmodule

`default_nettype wire

// ===== tb/color_match_column_centroid_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// color_match_column_centroid_tb
// Drives RGB pixel frames into the centroid block and checks every result
// word against a frame-by-frame model of the match count, column sum and
// rounded Q1.15 direction. A short table of directed pixels and register
// writes comes first. Then random frames follow under four flow-control
// modes, with register changes between and inside frames.
// ----------------------------------------------------------------------------

module color_match_column_centroid_tb;
  import cmcc_pkg::*;

  localparam int WIDTH_LIMIT = 1024;   // block's MAX_WIDTH
  localparam int SETTLE_CYCLES = 64;   // covers the divider latency
  localparam int RANDOM_PIXELS = 1950;
  localparam int NUM_PHASES = 8;
  localparam int NUM_ROWS = 28;

  typedef struct packed {
    logic [DIR_W-1:0] direction;
    logic [CNT_W-1:0] match_count;
    logic             direction_valid;
  } centroid_t;

  // one directed step: a register write or a pixel
  typedef struct packed {
    logic        is_reg;
    logic [2:0]  reg_idx;
    logic [31:0] value;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
    logic        typed;    // result written out below
    centroid_t   result;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // defaults: single match in column 0 is leftmost
    '{1'b0, REG_REF_RED, 32'd0, 8'd0, 8'd255, 8'd0, 1'b1, 1'b1, '{16'h8000, 21'd1, 1'b1}},
    // no match
    '{1'b0, REG_REF_RED, 32'd0, 8'd255, 8'd0, 8'd255, 1'b1, 1'b1, '{16'h0000, 21'd0, 1'b0}},
    // width of one, then zero acting as one
    '{1'b1, REG_WIDTH, 32'd1, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, '0},
    '{1'b0, REG_REF_RED, 32'd0, 8'd0, 8'd255, 8'd0, 1'b1, 1'b1, '{16'h0000, 21'd1, 1'b0}},
    '{1'b1, REG_WIDTH, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, '0},
    '{1'b0, REG_REF_RED, 32'd0, 8'd0, 8'd250, 8'd0, 1'b1, 1'b1, '{16'h0000, 21'd1, 1'b0}},
    // width two, match only in the right column: saturates high
    '{1'b1, REG_WIDTH, 32'd2, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, '0},
    '{1'b0, REG_REF_RED, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, '0},
    '{1'b0, REG_REF_RED, 32'd0, 8'd0, 8'd255, 8'd0, 1'b1, 1'b1, '{16'h7fff, 21'd1, 1'b1}},
    // zero threshold matches nothing
    '{1'b1, REG_THRESHOLD, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, '0},
    '{1'b0, REG_REF_RED, 32'd0, 8'd0, 8'd255, 8'd0, 1'b1, 1'b1, '{16'h0000, 21'd0, 1'b0}},
    // full-scale threshold, width above the limit, opposite reference
    '{1'b1, REG_THRESHOLD, 32'd1023, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, '0},
    '{1'b1, REG_WIDTH, 32'd2047, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, '0},
    '{1'b1, REG_REF_RED, 32'd255, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, '0},
    '{1'b1, REG_REF_GREEN, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, '0},
    '{1'b1, REG_REF_BLUE, 32'd255, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, '0},
    '{1'b0, REG_REF_RED, 32'd0, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0, '0},
    '{1'b0, REG_REF_RED, 32'd0, 8'd255, 8'd0, 8'd255, 1'b1, 1'b0, '0},
    // largest meaningful threshold, then the width shrinks mid-frame
    '{1'b1, REG_THRESHOLD, 32'd766, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, '0},
    '{1'b1, REG_WIDTH, 32'd8, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, '0},
    '{1'b0, REG_REF_RED, 32'd0, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0, '0},
    '{1'b0, REG_REF_RED, 32'd0, 8'd128, 8'd128, 8'd128, 1'b0, 1'b0, '0},
    '{1'b0, REG_REF_RED, 32'd0, 8'd255, 8'd0, 8'd255, 1'b0, 1'b0, '0},
    '{1'b0, REG_REF_RED, 32'd0, 8'd1, 8'd255, 8'd0, 1'b0, 1'b0, '0},
    '{1'b0, REG_REF_RED, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, '0},
    '{1'b1, REG_WIDTH, 32'd3, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, '0},
    '{1'b0, REG_REF_RED, 32'd0, 8'd255, 8'd0, 8'd255, 1'b0, 1'b0, '0},
    '{1'b0, REG_REF_RED, 32'd0, 8'd7, 8'd7, 8'd7, 1'b1, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16]
  logic        s_tlast = 1'b0; // end_of_frame
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // direction[15:0], match_count[36:16], pad[39:37]
  logic        m_tuser;        // direction_valid

  // model copy of the registers and the frame accumulators
  cfg_t             reg_copy = '{8'd0, 8'd255, 8'd0, 10'd10, 11'd320};
  logic [10:0]      col_pos = '0;
  logic [CNT_W-1:0] match_total = '0;
  logic [SUM_W-1:0] col_sum = '0;

  centroid_t expected_frames[$];
  int fail_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  color_match_column_centroid i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  initial begin
    #20_000_000;
    $display("color_match_column_centroid_tb failed");
    $finish;
  end

  function automatic logic [9:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? 10'(a - b) : 10'(b - a);
  endfunction

  // advance the accumulators by one pixel; returns 1 with the frame result
  function automatic bit centroid_step(input logic [7:0] red, input logic [7:0] green,
                                       input logic [7:0] blue, input logic eof,
                                       output centroid_t res);
    logic [10:0] w;
    logic [9:0]  color_dist;
    logic [63:0] acc;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] quo;
    res = '0;
    w = (reg_copy.frame_width == 0) ? 11'd1 :
        (reg_copy.frame_width > 11'(WIDTH_LIMIT)) ? 11'(WIDTH_LIMIT) : reg_copy.frame_width;
    if (col_pos >= w) col_pos = '0;
    color_dist = abs_diff(red, reg_copy.ref_red) + abs_diff(green, reg_copy.ref_green)
               + abs_diff(blue, reg_copy.ref_blue);
    if (color_dist < reg_copy.match_threshold) begin
      if (match_total != COUNT_MAX) match_total = match_total + 1'b1;
      acc = 64'(col_sum) + 64'(col_pos);
      col_sum = (acc > 64'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];
    end
    col_pos = col_pos + 1'b1;
    if (col_pos >= w) col_pos = '0;
    if (!eof) return 1'b0;
    res.match_count = match_total;
    if (match_total != 0 && w > 1) begin
      den = 64'(match_total) * 64'(w - 11'd1);
      num = (64'(col_sum) << 16) + den / 2;
      quo = num / den;
      if (quo > 64'd65535) quo = 64'd65535;
      res.direction = quo[15:0] ^ 16'h8000;   // q - 32768
      res.direction_valid = 1'b1;
    end
    col_pos = '0;
    match_total = '0;
    col_sum = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  // one pixel word; returns at the accepting edge
  task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue, input logic eof);
    centroid_t res;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {blue, green, red};
    s_tlast <= eof;
    do @(posedge clk); while (!s_tready);
    if (centroid_step(red, green, blue, eof, res)) expected_frames.push_back(res);
  endtask

  // stop sending, drain all results, let the pipeline settle
  task automatic quiesce();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write followed by a read-back; starts and ends at a falling edge
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    case (idx)
      REG_THRESHOLD: mask = 32'h3ff;
      REG_WIDTH:     mask = 32'h7ff;
      default:       mask = 32'hff;
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_REF_RED:   reg_copy.ref_red = value[7:0];
      REG_REF_GREEN: reg_copy.ref_green = value[7:0];
      REG_REF_BLUE:  reg_copy.ref_blue = value[7:0];
      REG_THRESHOLD: reg_copy.match_threshold = value[9:0];
      REG_WIDTH:     reg_copy.frame_width = value[10:0];
      default: ;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== (value & mask))
      report_mismatch("register read-back", 64'(value & mask), 64'(prdata));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_reg_value(input logic [2:0] idx);
    case (idx)
      REG_THRESHOLD:
        case ($urandom_range(7))
          0: return 32'd0;
          1: return 32'd766;
          2: return 32'd1023;
          3: return $urandom_range(1023);
          default: return $urandom_range(5, 200);
        endcase
      REG_WIDTH:
        case ($urandom_range(11))
          0: return 32'd0;
          1: return 32'd1;
          2: return 32'd1024;
          3: return 32'd2047;
          4: return $urandom_range(1025, 2046);
          5: return $urandom_range(49, 1023);
          default: return $urandom_range(2, 48);
        endcase
      default:
        case ($urandom_range(5))
          0: return 32'd0;
          1: return 32'd255;
          default: return $urandom_range(255);
        endcase
    endcase
  endfunction

  // pixel channel scattered around the reference so matches are common
  function automatic logic [7:0] near_channel(input logic [7:0] center, input int span);
    int v;
    v = int'(center) + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // receiver flow control
  always @(negedge clk) m_tready <= ($urandom_range(99) >= receiver_stall_pct);

  // result checker
  always @(posedge clk) begin : check_results
    centroid_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected result word", 64'd0, 64'({m_tuser, m_tdata}));
      end else begin
        want = expected_frames.pop_front();
        if (m_tdata[15:0] !== want.direction)
          report_mismatch("direction", 64'(want.direction), 64'(m_tdata[15:0]));
        if (m_tdata[36:16] !== want.match_count)
          report_mismatch("match_count", 64'(want.match_count), 64'(m_tdata[36:16]));
        if (m_tuser !== want.direction_valid)
          report_mismatch("direction_valid", 64'(want.direction_valid), 64'(m_tuser));
        if (m_tdata[39:37] !== 3'b000)
          report_mismatch("tdata pad", 64'd0, 64'(m_tdata[39:37]));
      end
    end
  end

  // stimulus
  initial begin
    int sent;
    int len;
    int span;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [2:0] idx;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED_ROWS[i].is_reg) begin
        quiesce();
        write_reg(DIRECTED_ROWS[i].reg_idx, DIRECTED_ROWS[i].value);
      end else begin
        send_pixel(DIRECTED_ROWS[i].red, DIRECTED_ROWS[i].green,
                   DIRECTED_ROWS[i].blue, DIRECTED_ROWS[i].last);
        if (DIRECTED_ROWS[i].typed)
          expected_frames[expected_frames.size() - 1] = DIRECTED_ROWS[i].result;
      end
    end

    // random frames: two setups per flow-control mode
    for (int k = 0; k < NUM_PHASES; k++) begin
      quiesce();
      case (k / 2)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 52; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 52; end
        default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
      endcase
      if (k == 0) begin
        write_reg(REG_REF_RED, 32'd255);
        write_reg(REG_REF_GREEN, 32'd255);
        write_reg(REG_REF_BLUE, 32'd255);
        write_reg(REG_THRESHOLD, 32'd766);
        write_reg(REG_WIDTH, 32'd1024);
      end else if (k == 1) begin
        write_reg(REG_REF_RED, 32'd0);
        write_reg(REG_REF_GREEN, 32'd0);
        write_reg(REG_REF_BLUE, 32'd0);
        write_reg(REG_THRESHOLD, 32'd1);
        write_reg(REG_WIDTH, 32'd2);
      end else begin
        for (int r = 0; r < 5; r++) write_reg(3'(r), rand_reg_value(3'(r)));
      end

      sent = 0;
      while (sent < RANDOM_PIXELS / NUM_PHASES) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 400) : $urandom_range(1, 24);
        // last frame of the phase stops at the pixel budget
        if (len > RANDOM_PIXELS / NUM_PHASES - sent) len = RANDOM_PIXELS / NUM_PHASES - sent;
        for (int j = 0; j < len; j++) begin
          // occasional register change, inside or between frames
          if ($urandom_range(199) == 0) begin
            quiesce();
            idx = 3'($urandom_range(4));
            write_reg(idx, rand_reg_value(idx));
          end
          span = int'(reg_copy.match_threshold) / 3 + 2;
          if ($urandom_range(99) < 60) begin
            red = near_channel(reg_copy.ref_red, span);
            green = near_channel(reg_copy.ref_green, span);
            blue = near_channel(reg_copy.ref_blue, span);
          end else begin
            red = 8'($urandom);
            green = 8'($urandom);
            blue = 8'($urandom);
          end
          send_pixel(red, green, blue, j == len - 1);
        end
        sent += len;
      end
    end

    // drain
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("color_match_column_centroid_tb passed");
    else
      $display("color_match_column_centroid_tb failed");
    $finish;
  end

endmodule
